### rtl/sobel_edge_magnitude_assert.svh
// Assertion macros used by the sobel edge magnitude controller.
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sem_pkg.sv
// Package: sizes, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);        // column counter
  localparam int ROW_W  = $clog2(MAX_HEIGHT);       // row counter
  localparam int WID_W  = 11;                       // image_width register
  localparam int HGT_W  = 13;                       // image_height register
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int MIN_DIM = 3;
  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

  // Register indexes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Datapath widths
  localparam int PIX_W  = 8;
  localparam int GRAD_W = 12;   // signed gradient, -1020..1020
  localparam int ABS_W  = 10;   // magnitude of one gradient
  localparam int SQ_W   = 2 * ABS_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int ROOT_W = 8;
  localparam int IDX_W  = $clog2(ROOT_W);

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;   // latch pixel, read both line stores
    logic calc;      // write line stores, form gradients, shift window, count
    logic mul;       // square both gradients
    logic sum;       // add squares, start root search
    logic step;      // one bit of the root search
    logic load;      // move result to the output register
  } sem_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic interior;  // current pixel completes an interior window
    logic root_last; // root search on its last bit
    logic out_free;  // output register can take a result this cycle
  } sem_sts_t;

endpackage

### rtl/sobel_edge_magnitude.sv
// Top level: streaming 3x3 Sobel edge magnitude with APB-style configuration.
`timescale 1ns / 1ps
// One grayscale pixel per in_ transfer in raster order; one 8-bit magnitude
// (floor of the gradient length, saturated at 255) per interior pixel, emitted
// when the pixel below-right of its centre arrives; border pixels give no
// result and out_frame_done marks the frame's last interior result. A border
// pixel occupies the block for the transfer and the line-store update. An
// interior pixel passes through transfer, line-store update and gradients,
// squaring, sum, 8 root steps (one result bit per cycle through a shared 8x8
// multiply-compare), and a load into the output register, which waits while
// the previous result is still untaken. The next pixel is taken while a result
// sits in the output register. Writing image_width or image_height restarts
// the frame at row 0, column 0; line stores need no clearing after reset.
module sobel_edge_magnitude (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sem_pkg::PIX_W-1:0]    in_pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sem_pkg::ROOT_W-1:0]   out_magnitude,
  output logic                         out_frame_done,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sem_pkg::ADDR_W-1:0]   paddr,
  input  logic [sem_pkg::DATA_W-1:0]   pwdata,
  output logic [sem_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import sem_pkg::*;

  sem_cmd_t         cmd;
  sem_sts_t         sts;
  logic [WID_W-1:0] eff_width;
  logic [HGT_W-1:0] eff_height;
  logic             restart;

  sem_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .restart    (restart)
  );

  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sem_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .eff_width      (eff_width),
    .eff_height     (eff_height),
    .restart        (restart),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_magnitude  (out_magnitude),
    .out_frame_done (out_frame_done)
  );

endmodule

### rtl/sem_regs.sv
// APB-style configuration registers with clamped image dimensions.
`timescale 1ns / 1ps
module sem_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sem_pkg::ADDR_W-1:0]   paddr,
  input  logic [sem_pkg::DATA_W-1:0]   pwdata,
  output logic [sem_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [sem_pkg::WID_W-1:0]    eff_width,
  output logic [sem_pkg::HGT_W-1:0]    eff_height,
  output logic                         restart
);
  import sem_pkg::*;

  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic             wr_en;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign restart = wr_en;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WIDTH:  width_r  <= pwdata[WID_W-1:0];
        REG_HEIGHT: height_r <= pwdata[HGT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

  // Clamp into the supported range
  always_comb begin
    if (width_r < WID_W'(MIN_DIM))        eff_width = WID_W'(MIN_DIM);
    else if (width_r > WID_W'(MAX_WIDTH)) eff_width = WID_W'(MAX_WIDTH);
    else                                  eff_width = width_r;
    if (height_r < HGT_W'(MIN_DIM))         eff_height = HGT_W'(MIN_DIM);
    else if (height_r > HGT_W'(MAX_HEIGHT)) eff_height = HGT_W'(MAX_HEIGHT);
    else                                    eff_height = height_r;
  end

endmodule

### rtl/sem_dp.sv
// Datapath: line stores, 3x3 window, gradients, squares, bit-serial root, output.
`timescale 1ns / 1ps
module sem_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sem_pkg::sem_cmd_t          cmd,
  output sem_pkg::sem_sts_t          sts,
  input  logic [sem_pkg::WID_W-1:0]  eff_width,
  input  logic [sem_pkg::HGT_W-1:0]  eff_height,
  input  logic                       restart,
  input  logic [sem_pkg::PIX_W-1:0]  in_pixel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sem_pkg::ROOT_W-1:0] out_magnitude,
  output logic                       out_frame_done
);
  import sem_pkg::*;

  // Line stores, no reset: an entry read before it was written never reaches a result
  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [PIX_W-1:0]  pix_r, top_r, mid_r;
  logic [PIX_W-1:0]  win_r [6];     // top x-2, top x-1, mid x-2, mid x-1, bot x-2, bot x-1
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [ABS_W-1:0]  ax_r, ay_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [SUM_W-1:0]  sum_r;
  logic [ROOT_W-1:0] root_r;
  logic [IDX_W-1:0]  idx_r;
  logic              flag_r;
  logic              out_valid_r;
  logic [ROOT_W-1:0] mag_r;
  logic              done_r;

  logic [WID_W-1:0]  col_inc;
  logic [HGT_W-1:0]  row_inc;
  logic              last_col, last_row;
  logic signed [GRAD_W-1:0] t0, t1, t2, m0, m2, b0, b1, b2, gx, gy, ax, ay;
  logic [ROOT_W-1:0]   trial;
  logic [2*ROOT_W-1:0] trial_sq;

  // Line store read on capture, write-back on calc
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r <= in_pixel;
      top_r <= upper_mem[col_r];
      mid_r <= middle_mem[col_r];
    end
    if (cmd.calc) begin
      upper_mem[col_r]  <= mid_r;
      middle_mem[col_r] <= pix_r;
    end
  end

  // Position and window
  assign col_inc  = WID_W'(col_r) + WID_W'(1);
  assign row_inc  = HGT_W'(row_r) + HGT_W'(1);
  assign last_col = (col_inc >= eff_width);
  assign last_row = (row_inc >= eff_height);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.calc) begin
      win_r[0] <= win_r[1];
      win_r[1] <= top_r;
      win_r[2] <= win_r[3];
      win_r[3] <= mid_r;
      win_r[4] <= win_r[5];
      win_r[5] <= pix_r;
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_r <= col_inc[COL_W-1:0];
      end
    end
  end

  assign sts.interior = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));

  // Sobel gradients
  always_comb begin
    t0 = $signed(GRAD_W'(win_r[0]));
    t1 = $signed(GRAD_W'(win_r[1]));
    t2 = $signed(GRAD_W'(top_r));
    m0 = $signed(GRAD_W'(win_r[2]));
    m2 = $signed(GRAD_W'(mid_r));
    b0 = $signed(GRAD_W'(win_r[4]));
    b1 = $signed(GRAD_W'(win_r[5]));
    b2 = $signed(GRAD_W'(pix_r));
    gx = t0 + (t1 <<< 1) + t2 - b0 - (b1 <<< 1) - b2;
    gy = t0 + (m0 <<< 1) + b0 - t2 - (m2 <<< 1) - b2;
    ax = gx[GRAD_W-1] ? -gx : gx;
    ay = gy[GRAD_W-1] ? -gy : gy;
  end

  // Magnitude arithmetic: abs -> squares -> sum -> root
  assign trial    = root_r | (ROOT_W'(1) << idx_r);
  assign trial_sq = trial * trial;
  assign sts.root_last = (idx_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      ax_r   <= ax[ABS_W-1:0];
      ay_r   <= ay[ABS_W-1:0];
      flag_r <= (row_inc == eff_height) && (col_inc == eff_width);
    end
    if (cmd.mul) begin
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
    end
    if (cmd.sum) begin
      sum_r  <= SUM_W'(sqx_r) + SUM_W'(sqy_r);
      root_r <= '0;
      idx_r  <= IDX_W'(ROOT_W - 1);
    end else if (cmd.step) begin
      // sums of 65536 and above accept every bit, giving 255
      if (SUM_W'(trial_sq) <= sum_r) root_r <= trial;
      idx_r <= idx_r - IDX_W'(1);
    end
  end

  // Output register
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r  <= root_r;
      done_r <= flag_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_magnitude  = mag_r;
  assign out_frame_done = done_r;

endmodule

### rtl/sem_ctrl.sv
// Controller: sequences one pixel through store update, squares and root search.
`timescale 1ns / 1ps
module sem_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sem_pkg::sem_sts_t sts,
  output sem_pkg::sem_cmd_t cmd
);
  import sem_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_LOAD = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.interior ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.step = 1'b1;
        if (sts.root_last) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`include "sobel_edge_magnitude_assert.svh"

  `SEM_ASSERT_NEXT(a_accept_to_calc, in_valid && in_ready, state_r == S_CALC, "transfer not followed by calc")
  `SEM_ASSERT_NEXT(a_border_returns, (state_r == S_CALC) && !sts.interior, state_r == S_IDLE, "border pixel did not return to idle")
  `SEM_ASSERT_NEXT(a_root_to_load, (state_r == S_ROOT) && sts.root_last, state_r == S_LOAD, "root search did not finish")
  `SEM_ASSERT_NEXT(a_sum_to_root, state_r == S_SUM, (state_r == S_ROOT) && !sts.root_last, "root search not started at top bit")

endmodule

### bench/tb_top.sv
// Self-checking testbench for the streaming 3x3 Sobel edge magnitude block.
`timescale 1ns / 1ps
module tb_top;
  import sem_pkg::*;

  localparam int RANDOM_ITEMS  = 1500;
  localparam int CALM_ITEMS    = 300;     // tail of the run with no idling
  localparam int SETTLE_CYCLES = 32;      // covers the processing of an interior pixel
  localparam int TIMEOUT_NS    = 40_000_000;
  localparam int DIR_CASES     = 15;

  localparam logic [ADDR_W-1:0] WIDTH_ADDR  = {REG_WIDTH, 2'b00};
  localparam logic [ADDR_W-1:0] HEIGHT_ADDR = {REG_HEIGHT, 2'b00};

  typedef enum logic [2:0] {
    PAT_FLAT, PAT_COL_STEP, PAT_ROW_STEP, PAT_DOT, PAT_NOISE, PAT_BINARY, PAT_NEAR
  } pixel_pattern_e;

  typedef struct packed {
    logic [ROOT_W-1:0] magnitude;
    logic              frame_done;
  } edge_result_t;

  // One directed case: register words, frame count plus extra pixels, image content
  typedef struct packed {
    logic [DATA_W-1:0] width_word;
    logic [DATA_W-1:0] height_word;
    int                frames;
    int                extra;
    pixel_pattern_e    pattern;
    logic [PIX_W-1:0]  a;
    logic [PIX_W-1:0]  b;
    int                fixed_mag;   // -1: predictor only
  } sobel_case_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PIX_W-1:0] in_pixel = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ROOT_W-1:0] out_magnitude;
  logic out_frame_done;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  sobel_edge_magnitude dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_magnitude(out_magnitude), .out_frame_done(out_frame_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: line stores, 3x2 window, raster position, registers
  logic [PIX_W-1:0] row_above [MAX_WIDTH];
  logic [PIX_W-1:0] row_middle [MAX_WIDTH];
  logic [PIX_W-1:0] win [6];
  int               col_pos = 0;
  int               row_pos = 0;
  logic [WID_W-1:0] width_reg = WIDTH_RESET;
  logic [HGT_W-1:0] height_reg = HEIGHT_RESET;

  edge_result_t pending_edges [$];
  int  typed_magnitude = -1;
  int  fault_count = 0;
  int  results_seen = 0;
  int  frames_seen = 0;
  int  pixels_sent = 0;
  int  settings_used = 0;
  bit  gap_enable = 1'b0;
  bit  stall_enable = 1'b0;
  int  out_stall_left = 0;

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_above[i] = '0;
      row_middle[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
  end

  function automatic int active_width();
    if (width_reg < MIN_DIM) return MIN_DIM;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    if (height_reg < MIN_DIM) return MIN_DIM;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  // Floor square root, bit by bit from the top; anything past 255^2 range saturates
  function automatic logic [ROOT_W-1:0] clamped_root(input int s);
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    if (s >= 65536) return '1;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root;
      trial[b] = 1'b1;
      if (int'(trial) * int'(trial) <= s) root = trial;
    end
    return root;
  endfunction

  // Advance the predictor by one accepted pixel, queueing the result it causes
  task automatic sobel_advance(input logic [PIX_W-1:0] px);
    int w, h, gx, gy;
    int t0, t1, t2, m0, m2, b0, b1, b2;
    logic [PIX_W-1:0] top, mid;
    edge_result_t res;
    w = active_width();
    h = active_height();
    top = row_above[col_pos];
    mid = row_middle[col_pos];
    row_above[col_pos] = mid;
    row_middle[col_pos] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      t0 = win[0]; t1 = win[1]; t2 = top;
      m0 = win[2];              m2 = mid;
      b0 = win[4]; b1 = win[5]; b2 = px;
      // row gradient: top minus bottom; column gradient: left minus right
      gx = t0 + 2 * t1 + t2 - b0 - 2 * b1 - b2;
      gy = t0 + 2 * m0 + b0 - t2 - 2 * m2 - b2;
      res.magnitude = clamped_root(gx * gx + gy * gy);
      res.frame_done = (row_pos + 1 == h) && (col_pos + 1 == w);
      pending_edges.push_back(res);
    end
    win[0] = win[1]; win[1] = top;
    win[2] = win[3]; win[3] = mid;
    win[4] = win[5]; win[5] = px;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic note_mismatch(input string what, input int expected, input int actual);
    fault_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expected, actual);
  endtask

  // Result checker: every out_ transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    edge_result_t due;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_edges.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result, expected none, actual magnitude %0d",
                 $time, out_magnitude);
      end else begin
        due = pending_edges.pop_front();
        if (out_magnitude !== due.magnitude)
          note_mismatch("magnitude", due.magnitude, out_magnitude);
        if (out_frame_done !== due.frame_done)
          note_mismatch("frame_done", due.frame_done, out_frame_done);
        if (typed_magnitude >= 0 && out_magnitude !== typed_magnitude)
          note_mismatch("fixed magnitude", typed_magnitude, out_magnitude);
        if (due.frame_done) frames_seen++;
      end
    end
  end

  // Result side back-pressure: random stall bursts on out_ready
  always @(posedge clk) begin
    if (out_stall_left != 0) begin
      out_stall_left--;
      out_ready <= 1'b0;
    end else if (stall_enable && $urandom_range(0, 9) == 0) begin
      out_stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One pixel transfer, then maybe an idle burst on the input side
  task automatic push_pixel(input logic [PIX_W-1:0] px);
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
    sobel_advance(px);
    pixels_sent++;
    if (gap_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Stop sending, wait for every predicted result, then let the pipeline settle
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    // a write restarts the frame; line stores and window are kept
    if (addr == WIDTH_ADDR) width_reg = data[WID_W-1:0];
    else height_reg = data[HGT_W-1:0];
    col_pos = 0;
    row_pos = 0;
    @(posedge clk);
  endtask

  task automatic apb_check(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] expected);
    logic [DATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== expected) note_mismatch("register read", expected, got);
    @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pattern_pixel(input pixel_pattern_e p, input int row,
      input int col, input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    case (p)
      PAT_FLAT:     return a;
      PAT_COL_STEP: return (col == 0) ? a : b;
      PAT_ROW_STEP: return (row == 0) ? a : b;
      PAT_DOT:      return (row == 0 && col == 0) ? a : b;
      PAT_NOISE:    return PIX_W'($urandom_range(0, 255));
      PAT_BINARY:   return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      PAT_NEAR:     return a + PIX_W'($urandom_range(0, 15));
      default:      return b;
    endcase
  endfunction

  // Send frames of the given content at the current effective size
  task automatic stream_pixels(input int count, input pixel_pattern_e p,
      input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    int ew, eh;
    ew = active_width();
    eh = active_height();
    for (int i = 0; i < count; i++)
      push_pixel(pattern_pixel(p, (i / ew) % eh, i % ew, a, b));
  endtask

  function automatic logic [WID_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return WID_W'($urandom_range(0, 2));
    if (r == 1) return WID_W'($urandom_range(13, 48));
    return WID_W'($urandom_range(3, 12));
  endfunction

  function automatic logic [HGT_W-1:0] pick_height();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return HGT_W'($urandom_range(0, 2));
    if (r == 1) return HGT_W'($urandom_range(9, 24));
    return HGT_W'($urandom_range(3, 8));
  endfunction

  sobel_case_t dir_cases [DIR_CASES];

  initial begin
    // flat images give zero, full steps saturate, then clamps and wraps
    dir_cases = '{
      '{32'd3,    32'd3,    1, 0, PAT_FLAT,     8'd0,   8'd0,   0},
      '{32'd3,    32'd3,    1, 0, PAT_FLAT,     8'd255, 8'd255, 0},
      '{32'd3,    32'd3,    1, 0, PAT_COL_STEP, 8'd255, 8'd0,   255},
      '{32'd3,    32'd3,    1, 0, PAT_COL_STEP, 8'd0,   8'd255, 255},
      '{32'd3,    32'd3,    1, 0, PAT_ROW_STEP, 8'd255, 8'd0,   255},
      '{32'd3,    32'd3,    1, 0, PAT_DOT,      8'd1,   8'd0,   -1},
      '{32'd3,    32'd3,    1, 0, PAT_COL_STEP, 8'd3,   8'd0,   -1},
      '{32'd0,    32'd0,    1, 0, PAT_FLAT,     8'd7,   8'd7,   0},
      '{32'd2,    32'd2,    2, 0, PAT_NOISE,    8'd0,   8'd0,   -1},
      '{32'd4,    32'd3,    2, 5, PAT_NOISE,    8'd0,   8'd0,   -1},
      '{32'd5,    32'd4,    1, 0, PAT_ROW_STEP, 8'd0,   8'd200, -1},
      '{32'd2047, 32'd3,    0, 40, PAT_NOISE,   8'd0,   8'd0,   -1},
      '{32'd3,    32'd8191, 0, 30, PAT_BINARY,  8'd0,   8'd0,   -1},
      '{32'd3,    32'd2,    1, 0, PAT_NEAR,     8'd100, 8'd0,   -1},
      '{32'd6,    32'd5,    1, 2, PAT_NEAR,     8'd245, 8'd0,   -1}
    };
  end

  initial begin : stimulus
    int random_pixels;
    int n, ew, eh, choice, r;
    bit calm;
    logic [DATA_W-1:0] word;
    pixel_pattern_e pat;
    logic [PIX_W-1:0] base;

    random_pixels = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers come up at their reset sizes
    apb_check(WIDTH_ADDR, 32'd640);
    apb_check(HEIGHT_ADDR, 32'd480);

    // directed cases
    for (int k = 0; k < DIR_CASES; k++) begin
      drain_block();
      typed_magnitude = -1;
      gap_enable = ($urandom_range(0, 1) != 0);
      stall_enable = ($urandom_range(0, 1) != 0);
      apb_write(WIDTH_ADDR, dir_cases[k].width_word);
      apb_check(WIDTH_ADDR, DATA_W'(width_reg));
      apb_write(HEIGHT_ADDR, dir_cases[k].height_word);
      apb_check(HEIGHT_ADDR, DATA_W'(height_reg));
      settings_used++;
      typed_magnitude = dir_cases[k].fixed_mag;
      n = dir_cases[k].frames * active_width() * active_height() + dir_cases[k].extra;
      stream_pixels(n, dir_cases[k].pattern, dir_cases[k].a, dir_cases[k].b);
    end

    // random phases: mostly whole frames, sometimes cut short by the next write
    while (random_pixels < RANDOM_ITEMS) begin
      drain_block();
      typed_magnitude = -1;
      calm = (RANDOM_ITEMS - random_pixels) < CALM_ITEMS;
      gap_enable = !calm && ($urandom_range(0, 3) != 0);
      stall_enable = !calm && ($urandom_range(0, 3) != 0);
      choice = $urandom_range(0, 2);
      if (choice != 2) begin
        word = $urandom;
        word[WID_W-1:0] = pick_width();
        apb_write(WIDTH_ADDR, word);
        apb_check(WIDTH_ADDR, DATA_W'(width_reg));
      end
      if (choice != 1) begin
        word = $urandom;
        word[HGT_W-1:0] = pick_height();
        apb_write(HEIGHT_ADDR, word);
        apb_check(HEIGHT_ADDR, DATA_W'(height_reg));
      end
      settings_used++;
      ew = active_width();
      eh = active_height();
      n = $urandom_range(1, 3) * ew * eh;
      if ($urandom_range(0, 2) == 0) n += $urandom_range(1, ew * eh - 1);
      r = $urandom_range(0, 3);
      pat = (r == 2) ? PAT_BINARY : (r == 3) ? PAT_NEAR : PAT_NOISE;
      base = PIX_W'($urandom_range(0, 255));
      stream_pixels(n, pat, base, 8'd0);
      random_pixels += n;
    end

    drain_block();
    $display("Covered %0d pixels and %0d edge results (%0d frame ends) over %0d size settings,",
             pixels_sent, results_seen, frames_seen, settings_used);
    $display("with size clamps, restarts mid-frame, frame wrap and idle bursts on both sides.");
    if (fault_count == 0) begin
      $display("sobel_edge_magnitude test passed");
    end else begin
      $display("sobel_edge_magnitude test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #TIMEOUT_NS;
    $display("Timeout with %0d results still due", pending_edges.size());
    $display("sobel_edge_magnitude test failed");
    $finish;
  end

endmodule
